// ----- src/lfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Lidar frame parser package
// Shared constants and the frame descriptor type passed from parser to
// point emitter.
// ----------------------------------------------------------------------------
package lfp_pkg;

  // Frame framing bytes.
  localparam logic [7:0] HDR_BYTE    = 8'h54;
  localparam logic [7:0] VERLEN_BYTE = 8'h2C;

  // Angles are in hundredths of a degree.
  localparam int          ANGLE_W     = 16;
  localparam logic [15:0] FULL_CIRCLE = 16'd36000;

  // Default number of points in one frame.
  localparam int POINTS_PER_FRAME_DEF = 12;

  // One point buffer word: distance in the upper bits, intensity below.
  localparam int DIST_W     = 16;
  localparam int INTENS_W   = 8;
  localparam int PT_DATA_W  = DIST_W + INTENS_W;

  // Frames that can be held between parser and emitter.
  localparam int FRAME_SLOTS = 2;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [15:0] frame_time;
  } frame_desc_t;

endpackage

// ----- src/lfp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lfp_desc_fifo.sv -----
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Short queue of completed frame headers between parser and emitter.
// ----------------------------------------------------------------------------
module lfp_desc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lfp_pkg::frame_desc_t push_desc,
  input  logic                pop,
  output lfp_pkg::frame_desc_t head_desc,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = lfp_pkg::FRAME_SLOTS;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lfp_pkg::frame_desc_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_desc = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/lfp_front.sv -----
// ----------------------------------------------------------------------------
// Frame parser front end
// Hunts for the frame header, collects frame fields and writes point data
// into the slot of the point buffer that belongs to the current frame.
// ----------------------------------------------------------------------------
module lfp_front #(
  parameter int POINTS_PER_FRAME = lfp_pkg::POINTS_PER_FRAME_DEF,
  parameter int PT_W             = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  input  logic [7:0]                    rx_byte,
  output logic                          desc_push,
  output lfp_pkg::frame_desc_t          desc,
  output logic                          pt_wr_en,
  output logic [PT_W:0]                 pt_wr_addr,
  output logic [lfp_pkg::PT_DATA_W-1:0] pt_wr_data
);

  localparam int DATA_BYTES = 9 + 3 * POINTS_PER_FRAME;
  localparam int CNT_W      = $clog2(DATA_BYTES);
  localparam int PTS_END    = 4 + 3 * POINTS_PER_FRAME;

  typedef enum logic [1:0] {
    HUNT,
    VER,
    DATA
  } phase_t;

  phase_t           phase;
  logic [CNT_W-1:0] byte_count;
  logic [1:0]       trip;
  logic [PT_W-1:0]  pt_idx;
  logic             wslot;
  logic [7:0]       dist_lo;
  logic [7:0]       dist_hi;
  logic             in_points;
  logic             last_byte;

  assign in_points  = (byte_count >= CNT_W'(4)) && (byte_count < CNT_W'(PTS_END));
  assign last_byte  = (byte_count == CNT_W'(DATA_BYTES - 1));
  assign desc_push  = byte_valid && (phase == DATA) && last_byte;
  assign pt_wr_en   = byte_valid && (phase == DATA) && in_points && (trip == 2'd2);
  assign pt_wr_addr = {wslot, pt_idx};
  assign pt_wr_data = {dist_hi, dist_lo, rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= HUNT;
      byte_count <= '0;
      trip       <= '0;
      pt_idx     <= '0;
      wslot      <= 1'b0;
    end else if (byte_valid) begin
      case (phase)
        HUNT: begin
          phase      <= (rx_byte == lfp_pkg::HDR_BYTE) ? VER : HUNT;
          byte_count <= '0;
        end
        VER: begin
          phase      <= (rx_byte == lfp_pkg::VERLEN_BYTE) ? DATA : HUNT;
          byte_count <= '0;
          trip       <= '0;
          pt_idx     <= '0;
        end
        DATA: begin
          if (last_byte) begin
            phase      <= HUNT;
            byte_count <= '0;
            wslot      <= ~wslot;
          end else begin
            byte_count <= byte_count + 1'b1;
          end
          if (in_points) begin
            if (trip == 2'd2) begin
              trip   <= '0;
              pt_idx <= pt_idx + 1'b1;
            end else begin
              trip <= trip + 1'b1;
            end
          end
        end
        default: begin
          phase      <= (rx_byte == lfp_pkg::HDR_BYTE) ? VER : HUNT;
          byte_count <= '0;
        end
      endcase
    end
  end

  // Frame fields are plain payload registers, written as their bytes arrive.
  always_ff @(posedge clk) begin
    if (byte_valid && (phase == DATA)) begin
      if (byte_count == CNT_W'(0)) begin
        desc.speed[7:0] <= rx_byte;
      end else if (byte_count == CNT_W'(1)) begin
        desc.speed[15:8] <= rx_byte;
      end else if (byte_count == CNT_W'(2)) begin
        desc.start_ang[7:0] <= rx_byte;
      end else if (byte_count == CNT_W'(3)) begin
        desc.start_ang[15:8] <= rx_byte;
      end else if (in_points) begin
        if (trip == 2'd0) begin
          dist_lo <= rx_byte;
        end else if (trip == 2'd1) begin
          dist_hi <= rx_byte;
        end
      end else if (byte_count == CNT_W'(PTS_END)) begin
        desc.end_ang[7:0] <= rx_byte;
      end else if (byte_count == CNT_W'(PTS_END + 1)) begin
        desc.end_ang[15:8] <= rx_byte;
      end else if (byte_count == CNT_W'(PTS_END + 2)) begin
        desc.frame_time[7:0] <= rx_byte;
      end else if (byte_count == CNT_W'(PTS_END + 3)) begin
        desc.frame_time[15:8] <= rx_byte;
      end
    end
  end

endmodule

// ----- src/lfp_back.sv -----
// ----------------------------------------------------------------------------
// Point emitter back end
// Works out the frame span and sweep total, splits the span over the points
// with a reciprocal multiply, and emits one point word at a time.
// ----------------------------------------------------------------------------
module lfp_back #(
  parameter int POINTS_PER_FRAME = lfp_pkg::POINTS_PER_FRAME_DEF,
  parameter int PT_W             = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          desc_empty,
  input  lfp_pkg::frame_desc_t          desc,
  output logic                          desc_pop,
  output logic                          rd_en,
  output logic [PT_W:0]                 rd_addr,
  input  logic [lfp_pkg::PT_DATA_W-1:0] rd_data,
  input  logic                          pop,
  output logic                          empty,
  output logic [15:0]                   point_angle,
  output logic [15:0]                   distance,
  output logic [7:0]                    intensity,
  output logic [3:0]                    point_index,
  output logic [15:0]                   spin_speed,
  output logic [15:0]                   frame_time,
  output logic                          last_of_frame,
  output logic                          sweep_done
);

  localparam int AW    = lfp_pkg::ANGLE_W;
  localparam int REM_W = $clog2(POINTS_PER_FRAME) + 1;
  localparam int SH    = AW + $clog2(POINTS_PER_FRAME);
  localparam int RCP_W = AW + 1;
  localparam int PRD_W = AW + RCP_W;
  localparam logic [REM_W:0]   DIV_EXT  = (REM_W + 1)'(POINTS_PER_FRAME);
  localparam logic [AW:0]      CIRC_EXT = {1'b0, lfp_pkg::FULL_CIRCLE};
  localparam logic [AW-1:0]    PTS_AW   = AW'(POINTS_PER_FRAME);
  // Rounded-up reciprocal of the point count; the quotient is exact for any
  // 16-bit span at this shift.
  localparam logic [RCP_W-1:0] RECIP    =
    RCP_W'(((64'd1 << SH) + 64'(POINTS_PER_FRAME) - 64'd1) / 64'(POINTS_PER_FRAME));

  typedef enum logic [2:0] {
    B_IDLE,
    B_FOLD,
    B_SPAN,
    B_DIV,
    B_REM,
    B_READ,
    B_LOAD
  } bstate_t;

  bstate_t          state;
  logic [AW-1:0]    s_ang;
  logic [AW-1:0]    e_ang;
  logic [AW-1:0]    span;
  logic [AW:0]      sweep;
  logic             full_flag;
  logic [AW-1:0]    q_step;
  logic [REM_W-1:0] r_step;
  logic [AW-1:0]    q_acc;
  logic [REM_W-1:0] r_acc;
  logic [PT_W-1:0]  j;
  logic             rslot;
  logic             out_valid;

  logic [AW-1:0]    s_fold;
  logic [AW-1:0]    e_fold;
  logic [AW-1:0]    span_c;
  logic [AW:0]      sweep_sum;
  logic [PRD_W-1:0] prod;
  logic [AW-1:0]    q_c;
  logic [AW-1:0]    q_times;
  logic [REM_W-1:0] r_c;
  logic [REM_W:0]   r_sum;
  logic             r_wrap;
  logic [AW:0]      ang_sum;
  logic [AW-1:0]    ang;
  logic             is_last;
  logic             out_free;
  logic             load_go;

  always_comb begin
    s_fold = (desc.start_ang >= lfp_pkg::FULL_CIRCLE) ?
             desc.start_ang - lfp_pkg::FULL_CIRCLE : desc.start_ang;
    e_fold = (desc.end_ang >= lfp_pkg::FULL_CIRCLE) ?
             desc.end_ang - lfp_pkg::FULL_CIRCLE : desc.end_ang;
    // A start past the end means the frame crossed zero degrees.
    span_c = (s_ang > e_ang) ? (lfp_pkg::FULL_CIRCLE - s_ang + e_ang) : (e_ang - s_ang);
    sweep_sum = sweep + {1'b0, span_c};

    // Quotient of the span by the point count, remainder one step later.
    prod    = {{RCP_W{1'b0}}, span} * {{AW{1'b0}}, RECIP};
    q_c     = AW'(prod >> SH);
    q_times = q_step * PTS_AW;
    r_c     = REM_W'(span - q_times);

    // Running quotient and remainder of j*span/points.
    r_sum  = {1'b0, r_acc} + {1'b0, r_step};
    r_wrap = (r_sum >= DIV_EXT);

    ang_sum = {1'b0, s_ang} + {1'b0, q_acc};
    ang     = (ang_sum >= CIRC_EXT) ? AW'(ang_sum - CIRC_EXT) : ang_sum[AW-1:0];
  end

  assign is_last  = (j == PT_W'(POINTS_PER_FRAME - 1));
  assign out_free = !out_valid || pop;
  assign load_go  = (state == B_LOAD) && out_free;
  assign desc_pop = load_go && is_last;
  assign rd_en    = (state == B_READ);
  assign rd_addr  = {rslot, j};
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      sweep     <= '0;
      rslot     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!desc_empty) begin
            state <= B_FOLD;
          end
        end
        B_FOLD: begin
          s_ang <= s_fold;
          e_ang <= e_fold;
          state <= B_SPAN;
        end
        B_SPAN: begin
          span <= span_c;
          if (sweep_sum >= CIRC_EXT) begin
            sweep     <= '0;
            full_flag <= 1'b1;
          end else begin
            sweep     <= sweep_sum;
            full_flag <= 1'b0;
          end
          state <= B_DIV;
        end
        B_DIV: begin
          q_step <= q_c;
          state  <= B_REM;
        end
        B_REM: begin
          r_step <= r_c;
          q_acc  <= '0;
          r_acc  <= '0;
          j      <= '0;
          state  <= B_READ;
        end
        B_READ: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          if (load_go) begin
            point_angle   <= ang;
            distance      <= rd_data[lfp_pkg::PT_DATA_W-1:lfp_pkg::INTENS_W];
            intensity     <= rd_data[lfp_pkg::INTENS_W-1:0];
            point_index   <= 4'(j);
            spin_speed    <= desc.speed;
            frame_time    <= desc.frame_time;
            last_of_frame <= is_last;
            sweep_done    <= is_last && full_flag;
            if (r_wrap) begin
              r_acc <= REM_W'(r_sum - DIV_EXT);
              q_acc <= q_acc + q_step + 1'b1;
            end else begin
              r_acc <= REM_W'(r_sum);
              q_acc <= q_acc + q_step;
            end
            if (is_last) begin
              rslot <= ~rslot;
              state <= B_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= B_READ;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lidar_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// Lidar frame parser
// Byte-serial frame parser with a two-frame queue to a point emitter.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while full is low; full rises only while two
// completed frames wait. After the crc, an idle emitter takes a frame through
// the fold, span, reciprocal divide and remainder steps, then each point
// through a registered point buffer read and a load that stalls while the
// output word is not popped. The first point appears at the first load.
// Reset (rst, synchronous): clears the parser phase, the frame queue, the
// sweep total and the output; the point buffer is not cleared.
module lidar_frame_parser_top #(
  parameter int POINTS_PER_FRAME = lfp_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] point_angle,
  output logic [15:0] distance,
  output logic [7:0]  intensity,
  output logic [3:0]  point_index,
  output logic [15:0] spin_speed,
  output logic [15:0] frame_time,
  output logic        last_of_frame,
  output logic        sweep_done
);

  localparam int PT_W      = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
  localparam int RAM_DEPTH = lfp_pkg::FRAME_SLOTS << PT_W;

  logic                          byte_valid;
  logic                          desc_push;
  lfp_pkg::frame_desc_t          front_desc;
  lfp_pkg::frame_desc_t          head_desc;
  logic                          desc_pop;
  logic                          desc_empty;
  logic                          pt_wr_en;
  logic [PT_W:0]                 pt_wr_addr;
  logic [lfp_pkg::PT_DATA_W-1:0] pt_wr_data;
  logic                          rd_en;
  logic [PT_W:0]                 rd_addr;
  logic [lfp_pkg::PT_DATA_W-1:0] rd_data;

  assign byte_valid = push && !full;

  lfp_front #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .PT_W            (PT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .rx_byte   (rx_byte),
    .desc_push (desc_push),
    .desc      (front_desc),
    .pt_wr_en  (pt_wr_en),
    .pt_wr_addr(pt_wr_addr),
    .pt_wr_data(pt_wr_data)
  );

  lfp_desc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (desc_push),
    .push_desc(front_desc),
    .pop      (desc_pop),
    .head_desc(head_desc),
    .full     (full),
    .empty    (desc_empty)
  );

  lfp_ram #(
    .WIDTH(lfp_pkg::PT_DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_pt_ram (
    .clk    (clk),
    .wr_en  (pt_wr_en),
    .wr_addr(pt_wr_addr),
    .wr_data(pt_wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lfp_back #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .PT_W            (PT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .desc_empty   (desc_empty),
    .desc         (head_desc),
    .desc_pop     (desc_pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .pop          (pop),
    .empty        (empty),
    .point_angle  (point_angle),
    .distance     (distance),
    .intensity    (intensity),
    .point_index  (point_index),
    .spin_speed   (spin_speed),
    .frame_time   (frame_time),
    .last_of_frame(last_of_frame),
    .sweep_done   (sweep_done)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar frame parser testbench
// Feeds link bytes through the push/full side and drains points through the
// empty/pop side, both with random idling. A directed table of frames comes
// first, then random frames mixed with broken headers and line noise. Every
// point word is compared field by field with an in-bench frame decoder.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int POINTS      = lfp_pkg::POINTS_PER_FRAME_DEF;
  localparam int BODY_LEN    = 9 + 3 * POINTS;
  localparam int ITEM_BUDGET = 420;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic [7:0] CRC_FILL = 8'h0E;
  localparam logic [7:0] HDR_B    = lfp_pkg::HDR_BYTE;
  localparam logic [7:0] VER_B    = lfp_pkg::VERLEN_BYTE;
  localparam int unsigned CIRCLE  = lfp_pkg::FULL_CIRCLE;

  typedef logic [7:0] octet_t;

  typedef enum logic [1:0] {HUNT, WANT_VERLEN, IN_BODY} link_phase_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_HDR, FILL_RAND} fill_t;
  typedef enum logic {K_FRAME, K_NOISE} row_kind_t;

  typedef struct {
    logic [15:0] angle;
    logic [15:0] meas;
    logic [7:0]  inten;
    logic [3:0]  idx;
    logic [15:0] speed;
    logic [15:0] stamp;
    logic        last;
    logic        circle_f;
  } point_t;

  // A noise row sends the speed bytes and then the stamp bytes, nothing else.
  typedef struct {
    row_kind_t   kind;
    octet_t      ver_byte;
    logic [15:0] speed;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [15:0] stamp;
    fill_t       fill;
    logic        typed;
    logic [15:0] last_ang;
    logic        last_full;
  } row_t;

  localparam int N_ROWS = 9;
  row_t plan [N_ROWS] = '{
    '{K_FRAME, VER_B, 'h0000, 0,     0,     'h0000, FILL_ZERO, 1, 0,     0},
    '{K_FRAME, VER_B, 'hFFFF, 0,     35999, 'hFFFF, FILL_ONES, 1, 32999, 0},
    '{K_FRAME, VER_B, 'h1234, 0,     1,     'h5678, FILL_RAND, 1, 0,     1},
    '{K_FRAME, VER_B, 'h00FF, 35999, 0,     'hFF00, FILL_RAND, 1, 35999, 0},
    '{K_FRAME, VER_B, 'h8000, 65535, 65535, 'h0001, FILL_RAND, 1, 29535, 0},
    '{K_FRAME, VER_B, 'h0E0E, 36000, 35999, 'h7FFF, FILL_RAND, 1, 32999, 1},
    '{K_FRAME, HDR_B, 'h002C, 0,     0,     'h0000, FILL_ZERO, 0, 0,     0},
    '{K_FRAME, VER_B, 'h5454, 'h2C54, 'h5454, 'h542C, FILL_HDR, 0, 0,    0},
    '{K_NOISE, VER_B, 'hFF00, 0,     0,     'h012C, FILL_ZERO, 0, 0,     0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] point_angle;
  logic [15:0] distance;
  logic [7:0]  intensity;
  logic [3:0]  point_index;
  logic [15:0] spin_speed;
  logic [15:0] frame_time;
  logic        last_of_frame;
  logic        sweep_done;

  lidar_frame_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .point_angle  (point_angle),
    .distance     (distance),
    .intensity    (intensity),
    .point_index  (point_index),
    .spin_speed   (spin_speed),
    .frame_time   (frame_time),
    .last_of_frame(last_of_frame),
    .sweep_done   (sweep_done)
  );

  // Decoder state, mirroring the parser.
  link_phase_t phase_m = HUNT;
  int unsigned body_idx = 0;
  logic [15:0] speed_m, start_m, end_m, stamp_m;
  logic [15:0] dist_m [POINTS];
  logic [7:0]  inten_m [POINTS];
  logic [16:0] sweep_m = '0;

  point_t points_due[$];
  octet_t pending[$];

  int  mismatches = 0;
  int  words_seen = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  int  pop_wait = 0;
  bit  pop_quiet = 1'b0;
  bit  send_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned fold_circle(input int unsigned a);
    return (a >= CIRCLE) ? a - CIRCLE : a;
  endfunction

  function automatic void emit_points();
    int unsigned s, e, span;
    bit wrapped;
    point_t p;
    s = fold_circle(start_m);
    e = fold_circle(end_m);
    span = (s > e) ? CIRCLE - s + e : e - s;
    sweep_m = 17'(sweep_m + span);
    wrapped = (sweep_m >= CIRCLE);
    if (wrapped) sweep_m = '0;
    for (int j = 0; j < POINTS; j++) begin
      p.angle    = 16'(fold_circle(s + (j * span) / POINTS));
      p.meas     = dist_m[j];
      p.inten    = inten_m[j];
      p.idx      = 4'(j);
      p.speed    = speed_m;
      p.stamp    = stamp_m;
      p.last     = (j == POINTS - 1);
      p.circle_f = (j == POINTS - 1) && wrapped;
      points_due.push_back(p);
    end
  endfunction

  // Advances the decoder by one accepted byte.
  function automatic void absorb_byte(input octet_t b);
    int unsigned k;
    case (phase_m)
      WANT_VERLEN: begin
        phase_m = (b == VER_B) ? IN_BODY : HUNT;
        body_idx = 0;
      end
      IN_BODY: begin
        k = body_idx;
        if (k == 0) speed_m[7:0] = b;
        else if (k == 1) speed_m[15:8] = b;
        else if (k == 2) start_m[7:0] = b;
        else if (k == 3) start_m[15:8] = b;
        else if (k < 4 + 3 * POINTS) begin
          case ((k - 4) % 3)
            0:       dist_m[(k - 4) / 3][7:0] = b;
            1:       dist_m[(k - 4) / 3][15:8] = b;
            default: inten_m[(k - 4) / 3] = b;
          endcase
        end
        else if (k == 4 + 3 * POINTS) end_m[7:0] = b;
        else if (k == 5 + 3 * POINTS) end_m[15:8] = b;
        else if (k == 6 + 3 * POINTS) stamp_m[7:0] = b;
        else if (k == 7 + 3 * POINTS) stamp_m[15:8] = b;
        if (k + 1 == BODY_LEN) begin
          phase_m = HUNT;
          body_idx = 0;
          emit_points();
        end else begin
          body_idx = k + 1;
        end
      end
      default: begin
        phase_m = (b == HDR_B) ? WANT_VERLEN : HUNT;
        body_idx = 0;
      end
    endcase
  endfunction

  function automatic void push_word16(input logic [15:0] w);
    pending.push_back(w[7:0]);
    pending.push_back(w[15:8]);
  endfunction

  function automatic void add_frame(input logic [15:0] speed, start_ang, end_ang, stamp,
                                    input fill_t fill, input octet_t ver_byte,
                                    input octet_t crc);
    logic [15:0] d;
    logic [7:0]  it;
    pending.push_back(HDR_B);
    pending.push_back(ver_byte);
    push_word16(speed);
    push_word16(start_ang);
    for (int j = 0; j < POINTS; j++) begin
      case (fill)
        FILL_ZERO: begin d = '0; it = '0; end
        FILL_ONES: begin d = '1; it = '1; end
        FILL_HDR:  begin d = {HDR_B, HDR_B}; it = VER_B; end
        default:   begin d = 16'($urandom); it = 8'($urandom); end
      endcase
      push_word16(d);
      pending.push_back(it);
    end
    push_word16(end_ang);
    push_word16(stamp);
    pending.push_back(crc);
  endfunction

  function automatic logic [15:0] rand_angle();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
  endfunction

  task automatic send_byte(input octet_t b);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_pending();
    octet_t b;
    while (pending.size() != 0) begin
      b = pending.pop_front();
      send_byte(b);
    end
  endtask

  // The sender stands still until every predicted point has been taken.
  task automatic hold_until_drained();
    push <= 1'b0;
    do @(posedge clk); while (points_due.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch on word %0d, %s: got %0d, want %0d", words_seen, what, got, want);
    mismatches++;
  endtask

  task automatic take_point_word();
    point_t want;
    if (points_due.size() == 0) begin
      note_mismatch("word with none expected", point_index, 0);
      words_seen++;
      return;
    end
    want = points_due.pop_front();
    if (point_angle !== want.angle) note_mismatch("point_angle", point_angle, want.angle);
    if (distance !== want.meas) note_mismatch("distance", distance, want.meas);
    if (intensity !== want.inten) note_mismatch("intensity", intensity, want.inten);
    if (point_index !== want.idx) note_mismatch("point_index", point_index, want.idx);
    if (spin_speed !== want.speed) note_mismatch("spin_speed", spin_speed, want.speed);
    if (frame_time !== want.stamp) note_mismatch("frame_time", frame_time, want.stamp);
    if (last_of_frame !== want.last)
      note_mismatch("last_of_frame", last_of_frame, want.last);
    if (sweep_done !== want.circle_f)
      note_mismatch("sweep_done", sweep_done, want.circle_f);
    words_seen++;
  endtask

  // Point side: check the word taken at this edge, then choose the next pop.
  always @(posedge clk) begin
    if (!rst && pop && !empty) take_point_word();
    if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      pop_wait <= pick_gap(pop_quiet);
    end
    if (cycles % 300 == 0) pop_quiet <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles, points_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t   r;
    point_t p;
    octet_t b;
    int     pick;
    int     n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      r = plan[i];
      send_quiet = ($urandom_range(0, 1) == 0);
      if (r.kind == K_NOISE) begin
        push_word16(r.speed);
        push_word16(r.stamp);
      end else begin
        add_frame(r.speed, r.start_ang, r.end_ang, r.stamp, r.fill, r.ver_byte, CRC_FILL);
      end
      send_pending();
      // Rows with a hand-worked last point replace the decoded one.
      if (r.typed) begin
        p = points_due.pop_back();
        p.angle = r.last_ang;
        p.circle_f = r.last_full;
        points_due.push_back(p);
      end
    end

    hold_until_drained();

    while (bytes_sent < ITEM_BUDGET) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        add_frame(16'($urandom), rand_angle(), rand_angle(), 16'($urandom), FILL_RAND,
                  VER_B, 8'($urandom));
      end else if (pick < 90) begin
        b = ($urandom_range(0, 2) == 0) ? HDR_B : 8'($urandom);
        if (b == VER_B) b = HDR_B;
        pending.push_back(HDR_B);
        pending.push_back(b);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) pending.push_back(8'($urandom));
      end
      send_pending();
    end

    push <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
